// ===== rtl/pcbs_pkg.sv =====
// shared types, opcodes and the microcode rom of the panel command byte sequencer
// no dependencies; imported by every module of the block
package pcbs_pkg;

	localparam int ADDR_W = 6;

	typedef logic [ADDR_W-1:0] ucode_addr_t;

	// request opcodes
	localparam logic [2:0] OP_INIT   = 3'd0;
	localparam logic [2:0] OP_SLEEP  = 3'd1;
	localparam logic [2:0] OP_WAKE   = 3'd2;
	localparam logic [2:0] OP_WINDOW = 3'd3;
	localparam logic [2:0] OP_PIXEL  = 3'd4;
	localparam logic [2:0] OP_ORIENT = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_COL_OFFSET  = 2'd0;
	localparam logic [1:0] REG_ROW_OFFSET  = 2'd1;
	localparam logic [1:0] REG_INIT_ORIENT = 2'd2;

	// program entry points
	localparam ucode_addr_t ADDR_INIT   = 6'd0;
	localparam ucode_addr_t ADDR_SLEEP  = 6'd17;
	localparam ucode_addr_t ADDR_WAKE   = 6'd19;
	localparam ucode_addr_t ADDR_WINDOW = 6'd21;
	localparam ucode_addr_t ADDR_PIXEL  = 6'd32;
	localparam ucode_addr_t ADDR_ORIENT = 6'd34;

	// where the byte of a step comes from
	typedef enum logic [3:0] {
		SRC_CONST  = 4'd0,
		SRC_ORIENT = 4'd1,
		SRC_C0_HI  = 4'd2,
		SRC_C0_LO  = 4'd3,
		SRC_C1_HI  = 4'd4,
		SRC_C1_LO  = 4'd5,
		SRC_R0_HI  = 4'd6,
		SRC_R0_LO  = 4'd7,
		SRC_R1_HI  = 4'd8,
		SRC_R1_LO  = 4'd9,
		SRC_PX_HI  = 4'd10,
		SRC_PX_LO  = 4'd11
	} byte_src_t;

	// one control word
	typedef struct packed {
		byte_src_t  src;
		logic [7:0] value;
		logic       is_data;
		logic       rel;
		logic       rel_fin;
		logic [7:0] wait_ms;
		logic       end_run;
	} ucode_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic busy;
		logic ending;
	} seq_stat_t;

	// one link byte with its marks
	typedef struct packed {
		logic [7:0] link_byte;
		logic       is_data;
		logic       release_select;
		logic [7:0] wait_ms;
		logic       last;
	} link_item_t;

	function automatic ucode_t uw(byte_src_t src, logic [7:0] value, logic is_data,
		logic rel, logic [7:0] wait_ms, logic end_run);
		ucode_t w;
		w.src     = src;
		w.value   = value;
		w.is_data = is_data;
		w.rel     = rel;
		w.rel_fin = 1'b0;
		w.wait_ms = wait_ms;
		w.end_run = end_run;
		return w;
	endfunction

	function automatic ucode_t ucode_rom(ucode_addr_t addr);
		ucode_t w;
		case (addr)
			// init table
			6'd0:  w = uw(SRC_CONST,  8'hFE, 1'b0, 1'b0, 8'd5,   1'b0);
			6'd1:  w = uw(SRC_CONST,  8'hEF, 1'b0, 1'b0, 8'd5,   1'b0);
			6'd2:  w = uw(SRC_CONST,  8'hB6, 1'b0, 1'b0, 8'd0,   1'b0);
			6'd3:  w = uw(SRC_CONST,  8'h19, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd4:  w = uw(SRC_CONST,  8'hAC, 1'b0, 1'b0, 8'd0,   1'b0);
			6'd5:  w = uw(SRC_CONST,  8'hC0, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd6:  w = uw(SRC_CONST,  8'hAB, 1'b0, 1'b0, 8'd0,   1'b0);
			6'd7:  w = uw(SRC_CONST,  8'h0E, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd8:  w = uw(SRC_CONST,  8'hA8, 1'b0, 1'b0, 8'd0,   1'b0);
			6'd9:  w = uw(SRC_CONST,  8'h19, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd10: w = uw(SRC_CONST,  8'h3A, 1'b0, 1'b0, 8'd0,   1'b0);
			6'd11: w = uw(SRC_CONST,  8'h05, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd12: w = uw(SRC_CONST,  8'h21, 1'b0, 1'b0, 8'd0,   1'b0);
			6'd13: w = uw(SRC_CONST,  8'h11, 1'b0, 1'b0, 8'd120, 1'b0);
			6'd14: w = uw(SRC_CONST,  8'h29, 1'b0, 1'b0, 8'd20,  1'b0);
			6'd15: w = uw(SRC_CONST,  8'h36, 1'b0, 1'b0, 8'd0,   1'b0);
			6'd16: w = uw(SRC_ORIENT, 8'h00, 1'b1, 1'b1, 8'd0,   1'b1);
			// sleep
			6'd17: w = uw(SRC_CONST,  8'h28, 1'b0, 1'b0, 8'd20,  1'b0);
			6'd18: w = uw(SRC_CONST,  8'h10, 1'b0, 1'b1, 8'd5,   1'b1);
			// wake
			6'd19: w = uw(SRC_CONST,  8'h11, 1'b0, 1'b0, 8'd120, 1'b0);
			6'd20: w = uw(SRC_CONST,  8'h29, 1'b0, 1'b1, 8'd20,  1'b1);
			// open window
			6'd21: w = uw(SRC_CONST,  8'h2A, 1'b0, 1'b0, 8'd0,   1'b0);
			6'd22: w = uw(SRC_C0_HI,  8'h00, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd23: w = uw(SRC_C0_LO,  8'h00, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd24: w = uw(SRC_C1_HI,  8'h00, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd25: w = uw(SRC_C1_LO,  8'h00, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd26: w = uw(SRC_CONST,  8'h2B, 1'b0, 1'b0, 8'd0,   1'b0);
			6'd27: w = uw(SRC_R0_HI,  8'h00, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd28: w = uw(SRC_R0_LO,  8'h00, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd29: w = uw(SRC_R1_HI,  8'h00, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd30: w = uw(SRC_R1_LO,  8'h00, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd31: w = uw(SRC_CONST,  8'h2C, 1'b0, 1'b0, 8'd0,   1'b1);
			// pixel, low byte releases select when it closes the window
			6'd32: w = uw(SRC_PX_HI,  8'h00, 1'b1, 1'b0, 8'd0,   1'b0);
			6'd33: begin
				w = uw(SRC_PX_LO, 8'h00, 1'b1, 1'b0, 8'd0, 1'b1);
				w.rel_fin = 1'b1;
			end
			// set orientation
			6'd34: w = uw(SRC_CONST,  8'h36, 1'b0, 1'b0, 8'd0,   1'b0);
			6'd35: w = uw(SRC_ORIENT, 8'h00, 1'b1, 1'b1, 8'd0,   1'b1);
			default: w = uw(SRC_CONST, 8'h00, 1'b0, 1'b1, 8'd0, 1'b1);
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/pcbs_sequencer.sv =====
// step counter and microcode rom lookup of the panel command byte sequencer
// depends on pcbs_pkg
module pcbs_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  pcbs_pkg::ucode_addr_t start_addr,
	input  logic                 advance,
	output pcbs_pkg::ucode_t     ctl,
	output pcbs_pkg::seq_stat_t  stat
);
	import pcbs_pkg::*;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'b01,
		SEQ_RUN  = 2'b10
	} seq_state_t;

	seq_state_t  state_q;
	ucode_addr_t pc_q;

	assign ctl         = ucode_rom(pc_q);
	assign stat.busy   = (state_q == SEQ_RUN);
	assign stat.ending = (state_q == SEQ_RUN) && ctl.end_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			pc_q    <= '0;
		end else if (start) begin
			state_q <= SEQ_RUN;
			pc_q    <= start_addr;
		end else if (advance) begin
			if (ctl.end_run) begin
				state_q <= SEQ_IDLE;
			end else begin
				pc_q <= pc_q + ucode_addr_t'(1);
			end
		end
	end

endmodule

// ===== rtl/pcbs_datapath.sv =====
// operand registers and byte selection driven by the current control word
// depends on pcbs_pkg
module pcbs_datapath (
	input  logic                 clk,
	input  logic                 load,
	input  logic [15:0]          first_column,
	input  logic [15:0]          first_row,
	input  logic [15:0]          last_column,
	input  logic [15:0]          last_row,
	input  logic [15:0]          pixel_color,
	input  logic                 final_pixel,
	input  logic [7:0]           orient,
	input  logic [7:0]           column_offset,
	input  logic [7:0]           row_offset,
	input  pcbs_pkg::ucode_t     ctl,
	output pcbs_pkg::link_item_t item
);
	import pcbs_pkg::*;

	logic [15:0] c0_q, c1_q, r0_q, r1_q, px_q;
	logic [7:0]  orient_q;
	logic        fin_q;

	// offsets wrap modulo 2^16
	always_ff @(posedge clk) begin
		if (load) begin
			c0_q     <= first_column + {8'h00, column_offset};
			c1_q     <= last_column + {8'h00, column_offset};
			r0_q     <= first_row + {8'h00, row_offset};
			r1_q     <= last_row + {8'h00, row_offset};
			px_q     <= pixel_color;
			fin_q    <= final_pixel;
			orient_q <= orient;
		end
	end

	always_comb begin
		case (ctl.src)
			SRC_CONST:  item.link_byte = ctl.value;
			SRC_ORIENT: item.link_byte = orient_q;
			SRC_C0_HI:  item.link_byte = c0_q[15:8];
			SRC_C0_LO:  item.link_byte = c0_q[7:0];
			SRC_C1_HI:  item.link_byte = c1_q[15:8];
			SRC_C1_LO:  item.link_byte = c1_q[7:0];
			SRC_R0_HI:  item.link_byte = r0_q[15:8];
			SRC_R0_LO:  item.link_byte = r0_q[7:0];
			SRC_R1_HI:  item.link_byte = r1_q[15:8];
			SRC_R1_LO:  item.link_byte = r1_q[7:0];
			SRC_PX_HI:  item.link_byte = px_q[15:8];
			SRC_PX_LO:  item.link_byte = px_q[7:0];
			default:    item.link_byte = ctl.value;
		endcase
		item.is_data        = ctl.is_data;
		item.release_select = ctl.rel | (ctl.rel_fin & fin_q);
		item.wait_ms        = ctl.wait_ms;
		item.last           = ctl.end_run;
	end

endmodule

// ===== rtl/panel_command_byte_sequencer_unit.sv =====
// panel command byte sequencer: turns requests into runs of panel link bytes
// start: a taken request loads the step counter, whose bytes pass the output register
// throughput: one byte per cycle from the microcode step counter while m_tready drains
//   the output register; bytes per request: 17 init, 2 sleep/wake/orient/pixel, 11 window
// reset: arst_n clears the sequencer, the window flag and the output valid and loads
//   the offset and orientation registers with 1, 2 and 0x68
// depends on pcbs_pkg, pcbs_sequencer, pcbs_datapath
module panel_command_byte_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // first_column, first_row, last_column, last_row,
	                               // pixel_color, orientation_value
	input  logic [2:0]  s_tuser,   // opcode
	input  logic        s_tlast,   // final_pixel
	// link byte stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // link_byte, wait_ms
	output logic [1:0]  m_tuser,   // is_data, release_select
	output logic        m_tlast,   // last byte of the request
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import pcbs_pkg::*;

	// request fields
	logic [15:0] first_column, first_row, last_column, last_row, pixel_color;
	logic [7:0]  orientation_value;
	logic [2:0]  opcode;

	assign first_column      = s_tdata[15:0];
	assign first_row         = s_tdata[31:16];
	assign last_column       = s_tdata[47:32];
	assign last_row          = s_tdata[63:48];
	assign pixel_color       = s_tdata[79:64];
	assign orientation_value = s_tdata[87:80];
	assign opcode            = s_tuser;

	// configuration registers, always ready
	logic [7:0] column_offset_q, row_offset_q, init_orientation_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_offset_q    <= 8'd1;
			row_offset_q       <= 8'd2;
			init_orientation_q <= 8'h68;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COL_OFFSET:  column_offset_q    <= cfg_data;
				REG_ROW_OFFSET:  row_offset_q       <= cfg_data;
				REG_INIT_ORIENT: init_orientation_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and datapath
	ucode_t     ctl;
	seq_stat_t  stat;
	link_item_t item;
	logic       step_fire;
	logic       accept;
	logic       go;
	ucode_addr_t entry;
	logic       window_open_q;
	logic       window_next;
	logic       m_tvalid_q;

	// a step runs when the output register is empty or being drained
	assign step_fire = stat.busy && (!m_tvalid_q || m_tready);
	// next request is taken on the same edge as the last step of the current run
	assign s_tready  = !stat.busy || (step_fire && stat.ending);
	assign accept    = s_tvalid && s_tready;

	// dispatch: pick the program entry and decide if the request plays at all
	always_comb begin
		go          = 1'b0;
		entry       = ADDR_INIT;
		window_next = window_open_q;
		case (opcode)
			OP_INIT: begin
				go          = 1'b1;
				entry       = ADDR_INIT;
				window_next = 1'b0;
			end
			OP_SLEEP: begin
				go          = 1'b1;
				entry       = ADDR_SLEEP;
				window_next = 1'b0;
			end
			OP_WAKE: begin
				go          = 1'b1;
				entry       = ADDR_WAKE;
				window_next = 1'b0;
			end
			OP_WINDOW: begin
				// reversed corners emit nothing and keep the window flag
				if (!(last_column < first_column) && !(last_row < first_row)) begin
					go          = 1'b1;
					entry       = ADDR_WINDOW;
					window_next = 1'b1;
				end
			end
			OP_PIXEL: begin
				// pixel with no open window is dropped
				if (window_open_q) begin
					go          = 1'b1;
					entry       = ADDR_PIXEL;
					window_next = !s_tlast;
				end
			end
			OP_ORIENT: begin
				go          = 1'b1;
				entry       = ADDR_ORIENT;
				window_next = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_open_q <= 1'b0;
		end else if (accept) begin
			window_open_q <= window_next;
		end
	end

	pcbs_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept && go),
		.start_addr (entry),
		.advance    (step_fire),
		.ctl        (ctl),
		.stat       (stat)
	);

	// init takes its last byte from the register, set orientation from the request
	pcbs_datapath u_dp (
		.clk           (clk),
		.load          (accept && go),
		.first_column  (first_column),
		.first_row     (first_row),
		.last_column   (last_column),
		.last_row      (last_row),
		.pixel_color   (pixel_color),
		.final_pixel   (s_tlast),
		.orient        ((opcode == OP_INIT) ? init_orientation_q : orientation_value),
		.column_offset (column_offset_q),
		.row_offset    (row_offset_q),
		.ctl           (ctl),
		.item          (item)
	);

	// output register parts the sequencer from the link side
	link_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			out_q <= item;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.wait_ms, out_q.link_byte};
	assign m_tuser  = {out_q.release_select, out_q.is_data};
	assign m_tlast  = out_q.last;

	// a request is only taken mid-run on the last step of that run
	a_accept_at_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.busy && accept) |-> (step_fire && stat.ending))
		else $error("request taken while a run is still in progress");

	// a pixel with no open window must not start a run
	a_pixel_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_PIXEL && !window_open_q) |=> !stat.busy)
		else $error("pixel played without an open window");

	// an accepted window run opens the window and starts playing
	a_window_opened: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_WINDOW && go) |=> (window_open_q && stat.busy))
		else $error("window open request did not open the window");

endmodule
